// ----- rtl/i2cm_pkg.sv -----
`default_nettype none
package i2cm_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;

	// command codes
	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_STOP  = 3'd2;
	localparam logic [2:0] MODE_WRITE = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;
	localparam logic [2:0] MODE_WACK  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_UNIT_TICKS  = 2'd0;
	localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

	localparam logic [9:0]  UNIT_TICKS_RST  = 10'd100;
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

	// sequencer phases
	localparam logic [4:0] PH_IDLE    = 5'd0;
	localparam logic [4:0] PH_ST1     = 5'd1;
	localparam logic [4:0] PH_ST2     = 5'd2;
	localparam logic [4:0] PH_SP1     = 5'd3;
	localparam logic [4:0] PH_SP2     = 5'd4;
	localparam logic [4:0] PH_SP3     = 5'd5;
	localparam logic [4:0] PH_WR_LOW  = 5'd6;
	localparam logic [4:0] PH_WR_HIGH = 5'd7;
	localparam logic [4:0] PH_WR_TAIL = 5'd8;
	localparam logic [4:0] PH_RD_LOW  = 5'd9;
	localparam logic [4:0] PH_RD_HIGH = 5'd10;
	localparam logic [4:0] PH_AK_LOW  = 5'd11;
	localparam logic [4:0] PH_AK_HIGH = 5'd12;
	localparam logic [4:0] PH_WA1     = 5'd13;
	localparam logic [4:0] PH_WA2     = 5'd14;
	localparam logic [4:0] PH_WA_POLL = 5'd15;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic       send_ack;
		logic       sda_level;
	} in_item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
	} out_item_t;

	// sequencer to phase timer
	typedef struct packed {
		logic        step;   // request accepted this cycle
		logic        count;  // advance the tick counter
		logic        clr;    // restart the phase timing
	} tmr_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/i2cm_timer.sv -----
`default_nettype none
module i2cm_timer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [9:0]         unit_ticks,
	input  wire logic [15:0]        len,
	input  wire i2cm_pkg::tmr_ctl_t ctl,
	output logic                    elapsed
);

	logic [9:0]  tick_q;
	logic [15:0] unit_q;
	logic [9:0]  ut;
	logic [15:0] n;
	logic [9:0]  tick_inc;
	logic        wrap;
	logic [9:0]  tick_nx;
	logic [15:0] unit_nx;

	always_comb begin
		ut       = (unit_ticks == 10'd0) ? 10'd1 : unit_ticks;
		n        = (len == 16'd0) ? 16'd1 : len;
		tick_inc = tick_q + 10'd1;
		wrap     = (tick_inc >= ut);
		tick_nx  = wrap ? 10'd0 : tick_inc;
		unit_nx  = wrap ? unit_q + 16'd1 : unit_q;
		elapsed  = (unit_nx >= n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			unit_q <= '0;
		end else if (ctl.step) begin
			if (ctl.clr) begin
				tick_q <= '0;
				unit_q <= '0;
			end else if (ctl.count) begin
				tick_q <= tick_nx;
				unit_q <= unit_nx;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/i2cm_seq.sv -----
`default_nettype none
module i2cm_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire i2cm_pkg::in_item_t  item,
	input  wire logic [15:0]         ack_timeout_units,
	input  wire logic                elapsed,
	output i2cm_pkg::tmr_ctl_t       tmr,
	output logic [15:0]              tmr_len,
	output i2cm_pkg::out_item_t      res
);

	logic [4:0] phase_q, phase_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic       ack_rd_q, ack_rd_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic [7:0] rx_q, rx_d;
	logic       fail_q, fail_d;
	logic       done;
	logic       enter;

	// phase length in units, from the current phase (and the ACK timeout in the poll phase)
	always_comb begin
		case (phase_q)
			i2cm_pkg::PH_ST1, i2cm_pkg::PH_ST2,
			i2cm_pkg::PH_SP1, i2cm_pkg::PH_SP3: tmr_len = 16'd4;
			i2cm_pkg::PH_WR_LOW, i2cm_pkg::PH_WR_HIGH, i2cm_pkg::PH_WR_TAIL,
			i2cm_pkg::PH_RD_LOW, i2cm_pkg::PH_AK_LOW, i2cm_pkg::PH_AK_HIGH: tmr_len = 16'd2;
			i2cm_pkg::PH_WA_POLL: tmr_len = ack_timeout_units;
			default: tmr_len = 16'd1;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		ack_rd_d = ack_rd_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		rx_d     = rx_q;
		fail_d   = fail_q;
		done     = 1'b0;
		enter    = 1'b0;
		tmr.step  = step;
		tmr.count = (phase_q != i2cm_pkg::PH_IDLE);

		case (phase_q)
			i2cm_pkg::PH_IDLE: begin
				tmr.count = 1'b0;
				if (item.mode inside {[i2cm_pkg::MODE_START : i2cm_pkg::MODE_WACK]}) begin
					bit_d = 4'd0;
					enter = 1'b1;
					case (item.mode)
						i2cm_pkg::MODE_START: begin
							phase_d = i2cm_pkg::PH_ST1; scl_d = 1'b1; sda_d = 1'b1;
						end
						i2cm_pkg::MODE_STOP: begin
							phase_d = i2cm_pkg::PH_SP1; scl_d = 1'b0; sda_d = 1'b0;
						end
						i2cm_pkg::MODE_WRITE: begin
							shift_d = item.data_byte;
							phase_d = i2cm_pkg::PH_WR_LOW; scl_d = 1'b0;
							sda_d   = item.data_byte[7];
						end
						i2cm_pkg::MODE_READ: begin
							shift_d  = 8'd0;
							ack_rd_d = item.send_ack;
							phase_d  = i2cm_pkg::PH_RD_LOW; scl_d = 1'b0; sda_d = 1'b1;
						end
						default: begin
							fail_d  = 1'b0;
							phase_d = i2cm_pkg::PH_WA1; sda_d = 1'b1;
						end
					endcase
				end
			end
			i2cm_pkg::PH_ST1: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_ST2; scl_d = 1'b1; sda_d = 1'b0;
				end
			end
			i2cm_pkg::PH_ST2: begin
				if (elapsed) begin
					scl_d = 1'b0; done = 1'b1;
				end
			end
			i2cm_pkg::PH_SP1: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_SP2; scl_d = 1'b1; sda_d = 1'b0;
				end
			end
			i2cm_pkg::PH_SP2: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_SP3; scl_d = 1'b1; sda_d = 1'b1;
				end
			end
			i2cm_pkg::PH_SP3: begin
				if (elapsed) done = 1'b1;
			end
			i2cm_pkg::PH_WR_LOW: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_WR_HIGH; scl_d = 1'b1;
				end
			end
			i2cm_pkg::PH_WR_HIGH: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_WR_TAIL; scl_d = 1'b0;
				end
			end
			i2cm_pkg::PH_WR_TAIL: begin
				if (elapsed) begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_d   = bit_q + 4'd1;
					if (bit_d >= 4'(i2cm_pkg::BITS_PER_BYTE)) begin
						done = 1'b1;
					end else begin
						enter = 1'b1; phase_d = i2cm_pkg::PH_WR_LOW; scl_d = 1'b0;
						sda_d = shift_q[6];
					end
				end
			end
			i2cm_pkg::PH_RD_LOW: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_RD_HIGH; scl_d = 1'b1; sda_d = 1'b1;
				end
			end
			i2cm_pkg::PH_RD_HIGH: begin
				if (elapsed) begin
					shift_d = {shift_q[6:0], item.sda_level};
					bit_d   = bit_q + 4'd1;
					enter   = 1'b1;
					scl_d   = 1'b0;
					if (bit_d >= 4'(i2cm_pkg::BITS_PER_BYTE)) begin
						phase_d = i2cm_pkg::PH_AK_LOW; sda_d = ~ack_rd_q;
					end else begin
						phase_d = i2cm_pkg::PH_RD_LOW; sda_d = 1'b1;
					end
				end
			end
			i2cm_pkg::PH_AK_LOW: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_AK_HIGH; scl_d = 1'b1;
				end
			end
			i2cm_pkg::PH_AK_HIGH: begin
				if (elapsed) begin
					scl_d = 1'b0; rx_d = shift_q; done = 1'b1;
				end
			end
			i2cm_pkg::PH_WA1: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_WA2; scl_d = 1'b1; sda_d = 1'b1;
				end
			end
			i2cm_pkg::PH_WA2: begin
				if (elapsed) begin
					enter = 1'b1; phase_d = i2cm_pkg::PH_WA_POLL; scl_d = 1'b1; sda_d = 1'b1;
				end
			end
			i2cm_pkg::PH_WA_POLL: begin
				if (!item.sda_level) begin
					scl_d = 1'b0; done = 1'b1;
				end else if (elapsed) begin
					fail_d = 1'b1;
					enter  = 1'b1; phase_d = i2cm_pkg::PH_SP1; scl_d = 1'b0; sda_d = 1'b0;
				end
			end
			default: begin
				// undefined phase code: drop back to idle
				tmr.count = 1'b0;
				phase_d   = i2cm_pkg::PH_IDLE;
			end
		endcase

		if (done) phase_d = i2cm_pkg::PH_IDLE;
		tmr.clr = enter | done;

		res.scl_release = scl_d;
		res.sda_release = sda_d;
		res.busy_res    = (phase_d != i2cm_pkg::PH_IDLE);
		res.done_res    = done;
		res.read_data   = rx_d;
		res.ack_missing = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= i2cm_pkg::PH_IDLE;
			bit_q    <= '0;
			shift_q  <= '0;
			ack_rd_q <= 1'b0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			rx_q     <= '0;
			fail_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			ack_rd_q <= ack_rd_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
			rx_q     <= rx_d;
			fail_q   <= fail_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/i2c_bit_level_master.sv -----
// The result of an accepted request is written to the output register at its accepting edge.
// Throughput: one request per cycle; a request is taken whenever the output
// register is empty or its result is being taken in the same cycle.
// Reset (arst_n low, asynchronous): idle, SCL and SDA released, counters and
// flags cleared, unit_ticks = 100, ack_timeout_units = 250, no result pending.
`default_nettype none
module i2c_bit_level_master (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire i2cm_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output i2cm_pkg::out_item_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);

	logic [9:0]          unit_ticks_q;
	logic [15:0]         ack_timeout_q;
	logic                step;
	logic                elapsed;
	i2cm_pkg::tmr_ctl_t  tmr;
	logic [15:0]         tmr_len;
	i2cm_pkg::out_item_t res;
	i2cm_pkg::out_item_t out_data_q;
	logic                out_valid_q;

	// Configuration: always ready; a write lands at its accepting edge and
	// applies from the next request on.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q  <= i2cm_pkg::UNIT_TICKS_RST;
			ack_timeout_q <= i2cm_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				i2cm_pkg::CFG_UNIT_TICKS:  unit_ticks_q  <= cfg_data[9:0];
				i2cm_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take a new request while the output register is free or draining now.
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	// Phase timer: ticks within a unit, units within a phase.
	i2cm_timer u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_ticks (unit_ticks_q),
		.len        (tmr_len),
		.ctl        (tmr),
		.elapsed    (elapsed)
	);

	// Line sequencer: one request advances the bus state by one tick.
	i2cm_seq u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.item              (in_data),
		.ack_timeout_units (ack_timeout_q),
		.elapsed           (elapsed),
		.tmr               (tmr),
		.tmr_len           (tmr_len),
		.res               (res)
	);

	// Output register: hold the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;

	// mode values outside the command set; the sequencer must ignore them
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;
	// register index that maps to nothing
	localparam logic [1:0] CFG_SPARE = 2'd3;
	// cycles with no handshake on any channel before the run is declared hung
	localparam int STALL_LIMIT = 4000;

	typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_drive_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	i2cm_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	i2cm_pkg::out_item_t out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [15:0]         cfg_data;

	i2c_bit_level_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Line sequencer predictor: register copies and sequencer state
	logic [9:0]  cfg_unit;
	logic [15:0] cfg_tmo;
	logic [4:0]  seq_ph;
	logic [3:0]  nbits;
	logic [7:0]  shreg;
	logic [9:0]  tcnt;
	logic [15:0] ucnt;
	logic        ack_rd;
	logic        scl_q;
	logic        sda_q;
	logic [7:0]  rx_byte;
	logic        nack_flag;

	i2cm_pkg::out_item_t expected_lines[$];

	// pacing controls shared by the sender, the sink and the test tasks
	bit tx_burst;
	bit rx_burst;
	int sink_hold;

	int n_ticks;
	int n_cmds;
	int n_timeouts;
	int n_checked;
	int n_errors;
	int n_settings;
	int quiet_cycles;

	// Switch to a new phase: set both line levels and restart unit timing.
	function automatic void enter_phase(logic [4:0] ph, logic scl, logic sda);
		seq_ph = ph;
		scl_q = scl;
		sda_q = sda;
		tcnt = '0;
		ucnt = '0;
	endfunction

	// Count one tick; true once len units have passed in the current phase.
	// A zero unit length or zero phase length behaves as one.
	function automatic logic units_elapsed(logic [15:0] len);
		logic [9:0]  ut;
		logic [15:0] n;
		ut = (cfg_unit == '0) ? 10'd1 : cfg_unit;
		n = (len == '0) ? 16'd1 : len;
		tcnt = tcnt + 10'd1;
		if (tcnt >= ut) begin
			tcnt = '0;
			ucnt = ucnt + 16'd1;
		end
		return ucnt >= n;
	endfunction

	// Advance the predicted sequencer by one accepted tick and return the line
	// levels and status it must report for that tick.
	function automatic i2cm_pkg::out_item_t line_step(i2cm_pkg::in_item_t it);
		i2cm_pkg::out_item_t r;
		logic                fin;
		fin = 1'b0;
		case (seq_ph)
			i2cm_pkg::PH_IDLE: begin
				// commands only start from idle; reserved modes fall through
				if (it.mode >= i2cm_pkg::MODE_START && it.mode <= i2cm_pkg::MODE_WACK) begin
					nbits = '0;
					case (it.mode)
						i2cm_pkg::MODE_START: enter_phase(i2cm_pkg::PH_ST1, 1'b1, 1'b1);
						i2cm_pkg::MODE_STOP:  enter_phase(i2cm_pkg::PH_SP1, 1'b0, 1'b0);
						i2cm_pkg::MODE_WRITE: begin
							shreg = it.data_byte;
							enter_phase(i2cm_pkg::PH_WR_LOW, 1'b0, it.data_byte[7]);
						end
						i2cm_pkg::MODE_READ: begin
							shreg = '0;
							ack_rd = it.send_ack;
							enter_phase(i2cm_pkg::PH_RD_LOW, 1'b0, 1'b1);
						end
						default: begin
							// wait for ACK keeps SCL where it was
							nack_flag = 1'b0;
							enter_phase(i2cm_pkg::PH_WA1, scl_q, 1'b1);
						end
					endcase
				end
			end
			i2cm_pkg::PH_ST1: if (units_elapsed(16'd4))
				enter_phase(i2cm_pkg::PH_ST2, 1'b1, 1'b0);
			i2cm_pkg::PH_ST2: if (units_elapsed(16'd4)) begin
				scl_q = 1'b0;
				fin = 1'b1;
			end
			i2cm_pkg::PH_SP1: if (units_elapsed(16'd4))
				enter_phase(i2cm_pkg::PH_SP2, 1'b1, 1'b0);
			i2cm_pkg::PH_SP2: if (units_elapsed(16'd1))
				enter_phase(i2cm_pkg::PH_SP3, 1'b1, 1'b1);
			i2cm_pkg::PH_SP3: if (units_elapsed(16'd4)) fin = 1'b1;
			i2cm_pkg::PH_WR_LOW: if (units_elapsed(16'd2))
				enter_phase(i2cm_pkg::PH_WR_HIGH, 1'b1, sda_q);
			i2cm_pkg::PH_WR_HIGH: if (units_elapsed(16'd2))
				enter_phase(i2cm_pkg::PH_WR_TAIL, 1'b0, sda_q);
			i2cm_pkg::PH_WR_TAIL: if (units_elapsed(16'd2)) begin
				shreg = shreg << 1;
				nbits = nbits + 4'd1;
				if (nbits >= i2cm_pkg::BITS_PER_BYTE)
					fin = 1'b1;
				else
					enter_phase(i2cm_pkg::PH_WR_LOW, 1'b0, shreg[7]);
			end
			i2cm_pkg::PH_RD_LOW: if (units_elapsed(16'd2))
				enter_phase(i2cm_pkg::PH_RD_HIGH, 1'b1, 1'b1);
			i2cm_pkg::PH_RD_HIGH: if (units_elapsed(16'd1)) begin
				// sample SDA on the last tick of the high unit
				shreg = {shreg[6:0], it.sda_level};
				nbits = nbits + 4'd1;
				if (nbits >= i2cm_pkg::BITS_PER_BYTE)
					enter_phase(i2cm_pkg::PH_AK_LOW, 1'b0, !ack_rd);
				else
					enter_phase(i2cm_pkg::PH_RD_LOW, 1'b0, 1'b1);
			end
			i2cm_pkg::PH_AK_LOW: if (units_elapsed(16'd2))
				enter_phase(i2cm_pkg::PH_AK_HIGH, 1'b1, sda_q);
			i2cm_pkg::PH_AK_HIGH: if (units_elapsed(16'd2)) begin
				scl_q = 1'b0;
				rx_byte = shreg;
				fin = 1'b1;
			end
			i2cm_pkg::PH_WA1: if (units_elapsed(16'd1))
				enter_phase(i2cm_pkg::PH_WA2, 1'b1, 1'b1);
			i2cm_pkg::PH_WA2: if (units_elapsed(16'd1))
				enter_phase(i2cm_pkg::PH_WA_POLL, 1'b1, 1'b1);
			i2cm_pkg::PH_WA_POLL: begin
				// ACK ends the wait at once; a timeout flags it and runs a stop
				if (!it.sda_level) begin
					scl_q = 1'b0;
					fin = 1'b1;
				end else if (units_elapsed(cfg_tmo)) begin
					nack_flag = 1'b1;
					n_timeouts++;
					enter_phase(i2cm_pkg::PH_SP1, 1'b0, 1'b0);
				end
			end
			default: seq_ph = i2cm_pkg::PH_IDLE;
		endcase
		if (fin) begin
			seq_ph = i2cm_pkg::PH_IDLE;
			tcnt = '0;
			ucnt = '0;
		end
		r.scl_release = scl_q;
		r.sda_release = sda_q;
		r.busy_res = (seq_ph != i2cm_pkg::PH_IDLE);
		r.done_res = fin;
		r.read_data = rx_byte;
		r.ack_missing = nack_flag;
		return r;
	endfunction

	function automatic logic pick_sda(sda_drive_t drv);
		case (drv)
			SDA_HIGH: return 1'b1;
			SDA_LOW:  return 1'b0;
			default:  return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// Offer one tick to the block, wait for the request to be taken and
	// record what it must produce. Valid stays high on return so that a
	// following tick can go out back to back.
	task automatic send_tick(logic [2:0] mode, logic [7:0] data, logic sack, logic sda);
		i2cm_pkg::in_item_t it;
		int                 gap;
		it.mode = mode;
		it.data_byte = data;
		it.send_ack = sack;
		it.sda_level = sda;
		gap = tx_burst ? 0 : int'($urandom_range(0, 13));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		expected_lines.push_back(line_step(it));
		n_ticks++;
	endtask

	// Issue one command from idle and keep ticking until the sequencer is
	// idle again. With noisy set, the ticks in between carry random modes
	// that a busy sequencer has to ignore.
	task automatic run_cmd(logic [2:0] mode, logic [7:0] data, logic sack, sda_drive_t drv,
			bit noisy);
		if (mode >= i2cm_pkg::MODE_START && mode <= i2cm_pkg::MODE_WACK)
			n_cmds++;
		send_tick(mode, data, sack, pick_sda(drv));
		while (seq_ph != i2cm_pkg::PH_IDLE)
			send_tick(noisy ? 3'($urandom_range(0, 7)) : i2cm_pkg::MODE_NONE,
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_sda(drv));
	endtask

	// Drop valid and hold until every predicted result has come back, then
	// let the output register settle.
	task automatic drain_lines();
		in_valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [15:0] val);
		drain_lines();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == i2cm_pkg::CFG_UNIT_TICKS)
			cfg_unit = val[9:0];
		else if (idx == i2cm_pkg::CFG_ACK_TIMEOUT)
			cfg_tmo = val;
	endtask

	task automatic set_timing(logic [15:0] unit, logic [15:0] tmo);
		write_register(i2cm_pkg::CFG_UNIT_TICKS, unit);
		write_register(i2cm_pkg::CFG_ACK_TIMEOUT, tmo);
		n_settings++;
	endtask

	// After reset, at the default timing: idle ticks and reserved modes only.
	task automatic test_reset_idle();
		send_tick(i2cm_pkg::MODE_NONE, 8'hFF, 1'b1, 1'b0);
		send_tick(MODE_RSVD6, 8'h00, 1'b0, 1'b1);
		send_tick(MODE_RSVD7, 8'hFF, 1'b1, 1'b1);
		send_tick(i2cm_pkg::MODE_NONE, 8'h00, 1'b0, 1'b0);
	endtask

	// Every command at the shortest timing, with data and SDA extremes.
	task automatic test_each_command();
		set_timing(16'd1, 16'd1);
		run_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_cmd(i2cm_pkg::MODE_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 1'b0);
		run_cmd(i2cm_pkg::MODE_WACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
		run_cmd(i2cm_pkg::MODE_WRITE, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
		run_cmd(i2cm_pkg::MODE_WACK, 8'h00, 1'b0, SDA_HIGH, 1'b0);
		run_cmd(i2cm_pkg::MODE_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
		run_cmd(i2cm_pkg::MODE_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
		run_cmd(i2cm_pkg::MODE_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
		run_cmd(i2cm_pkg::MODE_STOP, 8'h5A, 1'b1, SDA_RANDOM, 1'b1);
	endtask

	// Zero in either register must act as one; the spare index is inert.
	task automatic test_zero_registers();
		set_timing(16'd0, 16'd0);
		write_register(CFG_SPARE, 16'($urandom_range(0, 65535)));
		run_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_cmd(i2cm_pkg::MODE_WACK, 8'h00, 1'b0, SDA_HIGH, 1'b0);
	endtask

	// Long unit length and the largest ACK window; run flat out to keep it short.
	task automatic test_slow_timing();
		set_timing(16'd45, 16'd65535);
		tx_burst = 1'b1;
		rx_burst = 1'b1;
		run_cmd(i2cm_pkg::MODE_WACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
		set_timing(16'd1, 16'd65535);
		run_cmd(i2cm_pkg::MODE_WACK, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_cmd(i2cm_pkg::MODE_READ, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	// Hold the sink off for a long stretch while ticks keep coming, so the
	// output register fills and the input side has to stall.
	task automatic test_output_stall();
		set_timing(16'd1, 16'd2);
		tx_burst = 1'b1;
		sink_hold = 60;
		run_cmd(i2cm_pkg::MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM, 1'b1);
		run_cmd(i2cm_pkg::MODE_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
		tx_burst = 1'b0;
	endtask

	// One bus transfer: start, address, ACK wait, one or two data bytes
	// in the direction the address asks for, stop.
	task automatic random_transfer();
		logic [7:0] addr;
		int         nbytes;
		addr = 8'($urandom_range(0, 255));
		nbytes = int'($urandom_range(1, 2));
		run_cmd(i2cm_pkg::MODE_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			SDA_RANDOM, 1'b1);
		run_cmd(i2cm_pkg::MODE_WRITE, addr, 1'($urandom_range(0, 1)), SDA_RANDOM, 1'b1);
		run_cmd(i2cm_pkg::MODE_WACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			SDA_RANDOM, 1'b1);
		repeat (nbytes) begin
			if (addr[0]) begin
				run_cmd(i2cm_pkg::MODE_READ, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), SDA_RANDOM, 1'b1);
			end else begin
				run_cmd(i2cm_pkg::MODE_WRITE, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), SDA_RANDOM, 1'b1);
				run_cmd(i2cm_pkg::MODE_WACK, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), SDA_RANDOM, 1'b1);
			end
		end
		run_cmd(i2cm_pkg::MODE_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			SDA_RANDOM, 1'b1);
	endtask

	// Mostly complete transfers, some lone commands of any mode, with runs
	// of back-to-back traffic mixed among the idling ones.
	task automatic test_random_traffic(logic [15:0] unit, logic [15:0] tmo, int budget);
		int stop_at;
		set_timing(unit, tmo);
		stop_at = n_ticks + budget;
		while (n_ticks < stop_at) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = tx_burst;
			if ($urandom_range(0, 3) != 0)
				random_transfer();
			else
				run_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), SDA_RANDOM, 1'b1);
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		// predictor at its reset state
		cfg_unit = i2cm_pkg::UNIT_TICKS_RST;
		cfg_tmo = i2cm_pkg::ACK_TIMEOUT_RST;
		seq_ph = i2cm_pkg::PH_IDLE;
		nbits = '0;
		shreg = '0;
		tcnt = '0;
		ucnt = '0;
		ack_rd = 1'b0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		rx_byte = '0;
		nack_flag = 1'b0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		sink_hold = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_idle();
		test_each_command();
		test_zero_registers();
		test_slow_timing();
		test_output_stall();
		test_random_traffic(16'd1, 16'd1, 60);
		test_random_traffic(16'd2, 16'd3, 60);
		test_random_traffic(16'd1, 16'd65535, 60);
		test_random_traffic(16'd3, 16'd2, 60);

		drain_lines();
		repeat (10) @(posedge clk);
		$display("Run covered %0d ticks, %0d commands, %0d ACK timeouts, %0d timing settings.",
			n_ticks, n_cmds, n_timeouts, n_settings);
		$display("Compared %0d results field by field, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Result sink: stall a random number of cycles before each result, and
	// hold off for a whole stretch when a test asks for it.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			stall = rx_burst ? 0 : int'($urandom_range(0, 13));
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endtask

	// Compare each taken result with the oldest prediction.
	always @(posedge clk) begin : result_check
		i2cm_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_lines.size() == 0) begin
				$error("result taken with no prediction outstanding");
				n_errors++;
			end else begin
				want = expected_lines.pop_front();
				n_checked++;
				check_field("scl_release", 8'(want.scl_release), 8'(out_data.scl_release));
				check_field("sda_release", 8'(want.sda_release), 8'(out_data.sda_release));
				check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
				check_field("read_data", want.read_data, out_data.read_data);
				check_field("ack_missing", 8'(want.ack_missing), 8'(out_data.ack_missing));
			end
		end
	end

	// Watchdog: end the run if no channel moves a request for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles.", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
`default_nettype wire
